// ----- src/tacs_pkg.sv -----
`default_nettype none

package tacs_pkg;

    localparam int NUM_POINTS_DEF = 5;

    localparam int W_T   = 12;
    localparam int W_S   = 10;
    localparam int W_ST  = 16;
    localparam int W_STT = 28;
    localparam int W_SZ  = 14;
    localparam int W_SZT = 26;

    localparam int W_OPB = 28;
    localparam int W_COF = 64;
    localparam int W_ACC = 96;
    localparam int W_PRD = 62;
    localparam int W_MAG = 90;
    localparam int SCALE_SHIFT = 16;
    localparam int N_COF_TERMS = 15;

    localparam logic [3:0] A_SXX = 4'd0;
    localparam logic [3:0] A_SYY = 4'd1;
    localparam logic [3:0] A_SXY = 4'd2;
    localparam logic [3:0] A_SX  = 4'd3;
    localparam logic [3:0] A_SY  = 4'd4;
    localparam logic [3:0] A_CA  = 4'd5;
    localparam logic [3:0] A_CB  = 4'd6;
    localparam logic [3:0] A_CC  = 4'd7;
    localparam logic [3:0] A_CE  = 4'd8;
    localparam logic [3:0] A_CF  = 4'd9;
    localparam logic [3:0] A_CI  = 4'd10;

    localparam logic [2:0] B_SYY = 3'd0;
    localparam logic [2:0] B_SXY = 3'd1;
    localparam logic [2:0] B_SY  = 3'd2;
    localparam logic [2:0] B_SX  = 3'd3;
    localparam logic [2:0] B_N   = 3'd4;
    localparam logic [2:0] B_Z   = 3'd5;
    localparam logic [2:0] B_ZT  = 3'd6;
    localparam logic [2:0] B_ZU  = 3'd7;

    localparam logic [2:0] D_NONE = 3'd0;
    localparam logic [2:0] D_A    = 3'd1;
    localparam logic [2:0] D_B    = 3'd2;
    localparam logic [2:0] D_C    = 3'd3;
    localparam logic [2:0] D_E    = 3'd4;
    localparam logic [2:0] D_F    = 3'd5;
    localparam logic [2:0] D_I    = 3'd6;
    localparam logic [2:0] D_DET  = 3'd7;

    localparam logic [2:0] IDX_SCALE = 3'd6;

    typedef struct packed {
        logic [W_T-1:0] touch_x;
        logic [W_T-1:0] touch_y;
        logic [W_S-1:0] target_x;
        logic [W_S-1:0] target_y;
    } t_item;

    typedef struct packed {
        logic [2:0]         coef_index;
        logic signed [31:0] coef_value;
        logic               singular;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [W_ST-1:0]  sum_tx;
        logic [W_ST-1:0]  sum_ty;
        logic [W_STT-1:0] sum_txx;
        logic [W_STT-1:0] sum_tyy;
        logic [W_STT-1:0] sum_txy;
        logic [W_SZ-1:0]  sum_sx;
        logic [W_SZT-1:0] sum_sx_tx;
        logic [W_SZT-1:0] sum_sx_ty;
        logic [W_SZ-1:0]  sum_sy;
        logic [W_SZT-1:0] sum_sy_tx;
        logic [W_SZT-1:0] sum_sy_ty;
    } t_sums;

    typedef struct packed {
        logic [3:0] a_sel;
        logic [2:0] b_sel;
        logic       neg;
        logic [2:0] dest;
    } t_term;

    function automatic t_term cof_term(input logic [3:0] idx);
        t_term t;
        unique case (idx)
            4'd0:    t = '{A_SXX, B_SYY, 1'b0, D_NONE};
            4'd1:    t = '{A_SXY, B_SXY, 1'b1, D_A};
            4'd2:    t = '{A_SXY, B_SY,  1'b0, D_NONE};
            4'd3:    t = '{A_SX,  B_SYY, 1'b1, D_B};
            4'd4:    t = '{A_SXY, B_SX,  1'b0, D_NONE};
            4'd5:    t = '{A_SXX, B_SY,  1'b1, D_C};
            4'd6:    t = '{A_SYY, B_N,   1'b0, D_NONE};
            4'd7:    t = '{A_SY,  B_SY,  1'b1, D_E};
            4'd8:    t = '{A_SX,  B_SY,  1'b0, D_NONE};
            4'd9:    t = '{A_SXY, B_N,   1'b1, D_F};
            4'd10:   t = '{A_SXX, B_N,   1'b0, D_NONE};
            4'd11:   t = '{A_SX,  B_SX,  1'b1, D_I};
            4'd12:   t = '{A_CA,  B_N,   1'b0, D_NONE};
            4'd13:   t = '{A_CB,  B_SX,  1'b0, D_NONE};
            4'd14:   t = '{A_CC,  B_SY,  1'b0, D_DET};
            default: t = '{A_SXX, B_N,   1'b0, D_NONE};
        endcase
        return t;
    endfunction

    function automatic logic [3:0] coef_a(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] s;
        unique case ({row, col})
            4'b0000: s = A_CA;
            4'b0001: s = A_CB;
            4'b0010: s = A_CC;
            4'b0100: s = A_CB;
            4'b0101: s = A_CE;
            4'b0110: s = A_CF;
            4'b1000: s = A_CC;
            4'b1001: s = A_CF;
            4'b1010: s = A_CI;
            default: s = A_CA;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- src/tacs_queue.sv -----
`default_nettype none

module tacs_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire tacs_pkg::t_sums i_data,
    input  wire logic            i_pop,
    output tacs_pkg::t_sums      o_data,
    output logic [1:0]           o_count
);

    tacs_pkg::t_sums r_mem [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ----- src/tacs_front.sv -----
`default_nettype none

module tacs_front #(
    parameter int NUM_POINTS = tacs_pkg::NUM_POINTS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire tacs_pkg::t_item i_item,
    input  wire logic [1:0]      i_q_count,
    output logic                 o_busy,
    output logic                 o_push,
    output tacs_pkg::t_sums      o_push_data
);

    localparam int CW = $clog2(NUM_POINTS);

    logic [CW-1:0]    r_cnt;
    logic             r_v;
    logic             r_last;
    tacs_pkg::t_item  r_item;
    logic [23:0]      r_pxx, r_pyy, r_pxy;
    logic [21:0]      r_psx_x, r_psx_y, r_psy_x, r_psy_y;
    tacs_pkg::t_sums  r_sums;
    tacs_pkg::t_sums  n_sums;
    logic             accept;
    logic             is_last;
    logic [2:0]       load;

    assign load    = 3'(i_q_count) + 3'(r_v && r_last);
    assign o_busy  = load >= 3'd2;
    assign accept  = i_start && !o_busy;
    assign is_last = r_cnt == CW'(NUM_POINTS - 1);

    always_comb begin
        n_sums.sum_tx    = r_sums.sum_tx + tacs_pkg::W_ST'(r_item.touch_x);
        n_sums.sum_ty    = r_sums.sum_ty + tacs_pkg::W_ST'(r_item.touch_y);
        n_sums.sum_txx   = r_sums.sum_txx + tacs_pkg::W_STT'(r_pxx);
        n_sums.sum_tyy   = r_sums.sum_tyy + tacs_pkg::W_STT'(r_pyy);
        n_sums.sum_txy   = r_sums.sum_txy + tacs_pkg::W_STT'(r_pxy);
        n_sums.sum_sx    = r_sums.sum_sx + tacs_pkg::W_SZ'(r_item.target_x);
        n_sums.sum_sx_tx = r_sums.sum_sx_tx + tacs_pkg::W_SZT'(r_psx_x);
        n_sums.sum_sx_ty = r_sums.sum_sx_ty + tacs_pkg::W_SZT'(r_psx_y);
        n_sums.sum_sy    = r_sums.sum_sy + tacs_pkg::W_SZ'(r_item.target_y);
        n_sums.sum_sy_tx = r_sums.sum_sy_tx + tacs_pkg::W_SZT'(r_psy_x);
        n_sums.sum_sy_ty = r_sums.sum_sy_ty + tacs_pkg::W_SZT'(r_psy_y);
    end

    assign o_push      = r_v && r_last;
    assign o_push_data = n_sums;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item  <= i_item;
            r_pxx   <= i_item.touch_x * i_item.touch_x;
            r_pyy   <= i_item.touch_y * i_item.touch_y;
            r_pxy   <= i_item.touch_x * i_item.touch_y;
            r_psx_x <= i_item.target_x * i_item.touch_x;
            r_psx_y <= i_item.target_x * i_item.touch_y;
            r_psy_x <= i_item.target_y * i_item.touch_x;
            r_psy_y <= i_item.target_y * i_item.touch_y;
            r_last  <= is_last;
        end
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_v    <= 1'b0;
            r_sums <= '0;
        end else begin
            r_v <= accept;
            if (accept) begin
                r_cnt <= is_last ? '0 : r_cnt + CW'(1);
            end
            if (r_v) begin
                r_sums <= r_last ? '0 : n_sums;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/tacs_solver.sv -----
`default_nettype none

module tacs_solver #(
    parameter int NUM_POINTS = tacs_pkg::NUM_POINTS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [1:0]      i_q_count,
    input  wire tacs_pkg::t_sums i_q_data,
    output logic                 o_q_pop,
    output logic                 o_strobe,
    output tacs_pkg::t_result    o_result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;

    localparam int WC = tacs_pkg::W_COF;
    localparam int WA = tacs_pkg::W_ACC;
    localparam int WM = tacs_pkg::W_MAG;
    localparam int WB = tacs_pkg::W_OPB;

    logic [2:0]                 r_state;
    tacs_pkg::t_sums            r_s;
    logic [1:0]                 r_phase;
    logic [3:0]                 r_term;
    logic                       r_mode;
    logic [1:0]                 r_row;
    logic                       r_grp;
    logic [1:0]                 r_j;
    logic signed [WA-1:0]       r_acc;
    logic signed [tacs_pkg::W_PRD-1:0] r_prod;
    logic signed [WC-1:0]       r_ca, r_cb, r_cc, r_ce, r_cf, r_ci, r_det;
    logic [WM-1:0]              r_dvd;
    logic [WC-2:0]              r_rem;
    logic [WC-2:0]              r_dmag;
    logic                       r_neg;
    logic [6:0]                 r_bit;
    logic                       r_out_v;
    tacs_pkg::t_result          r_out;

    tacs_pkg::t_term            cur;
    logic [2:0]                 b_j;
    logic signed [WC-1:0]       a_val;
    logic [WB-1:0]              b_val;
    logic signed [32:0]         m_a;
    logic signed [WB:0]         m_b;
    logic signed [tacs_pkg::W_PRD-1:0] m_p;
    logic signed [WA-1:0]       addend;
    logic signed [WA-1:0]       n_acc;
    logic [WA-1:0]              acc_abs;
    logic [WC-1:0]              det_abs;
    logic                       expr_end;
    logic [WC-1:0]              rem_sh;
    logic                       q_ge;
    logic [WC-1:0]              rem_nx;
    logic [2:0]                 out_idx;
    logic [31:0]                sat_val;

    always_comb begin
        unique case (r_j)
            2'd0:    b_j = tacs_pkg::B_Z;
            2'd1:    b_j = tacs_pkg::B_ZT;
            default: b_j = tacs_pkg::B_ZU;
        endcase
        if (r_mode) begin
            cur = '{tacs_pkg::coef_a(r_row, r_j), b_j, 1'b0, tacs_pkg::D_NONE};
        end else begin
            cur = tacs_pkg::cof_term(r_term);
        end
    end

    always_comb begin
        unique case (cur.a_sel)
            tacs_pkg::A_SXX: a_val = WC'(r_s.sum_txx);
            tacs_pkg::A_SYY: a_val = WC'(r_s.sum_tyy);
            tacs_pkg::A_SXY: a_val = WC'(r_s.sum_txy);
            tacs_pkg::A_SX:  a_val = WC'(r_s.sum_tx);
            tacs_pkg::A_SY:  a_val = WC'(r_s.sum_ty);
            tacs_pkg::A_CA:  a_val = r_ca;
            tacs_pkg::A_CB:  a_val = r_cb;
            tacs_pkg::A_CC:  a_val = r_cc;
            tacs_pkg::A_CE:  a_val = r_ce;
            tacs_pkg::A_CF:  a_val = r_cf;
            tacs_pkg::A_CI:  a_val = r_ci;
            default:         a_val = '0;
        endcase
        unique case (cur.b_sel)
            tacs_pkg::B_SYY: b_val = WB'(r_s.sum_tyy);
            tacs_pkg::B_SXY: b_val = WB'(r_s.sum_txy);
            tacs_pkg::B_SY:  b_val = WB'(r_s.sum_ty);
            tacs_pkg::B_SX:  b_val = WB'(r_s.sum_tx);
            tacs_pkg::B_N:   b_val = WB'(NUM_POINTS);
            tacs_pkg::B_Z:   b_val = r_grp ? WB'(r_s.sum_sy) : WB'(r_s.sum_sx);
            tacs_pkg::B_ZT:  b_val = r_grp ? WB'(r_s.sum_sy_tx) : WB'(r_s.sum_sx_tx);
            default:         b_val = r_grp ? WB'(r_s.sum_sy_ty) : WB'(r_s.sum_sx_ty);
        endcase
    end

    assign m_a = (r_phase == 2'd0) ? {1'b0, a_val[31:0]} : {a_val[WC-1], a_val[WC-1:32]};
    assign m_b = {1'b0, b_val};
    assign m_p = m_a * m_b;

    assign addend   = (r_phase == 2'd2) ? (WA'(r_prod) <<< 32) : WA'(r_prod);
    assign n_acc    = cur.neg ? r_acc - addend : r_acc + addend;
    assign acc_abs  = n_acc[WA-1] ? WA'(-n_acc) : WA'(n_acc);
    assign det_abs  = r_det[WC-1] ? WC'(-r_det) : WC'(r_det);
    assign expr_end = r_mode ? (r_j == 2'd2) : (cur.dest != tacs_pkg::D_NONE);

    assign rem_sh = {r_rem, r_dvd[WM-1]};
    assign q_ge   = rem_sh >= {1'b0, r_dmag};
    assign rem_nx = q_ge ? rem_sh - {1'b0, r_dmag} : rem_sh;

    assign out_idx = 3'(r_row) + (r_grp ? 3'd3 : 3'd0);

    always_comb begin
        if (!r_neg) begin
            sat_val = (|r_dvd[WM-1:31]) ? 32'h7FFF_FFFF : {1'b0, r_dvd[30:0]};
        end else if ((|r_dvd[WM-1:32]) || (r_dvd[31] && (|r_dvd[30:0]))) begin
            sat_val = 32'h8000_0000;
        end else begin
            sat_val = -r_dvd[31:0];
        end
    end

    assign o_q_pop = (r_state == ST_IDLE) && (i_q_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_v <= 1'b0;
            r_phase <= 2'd0;
            r_mode  <= 1'b0;
        end else begin
            r_out_v <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        r_s     <= i_q_data;
                        r_term  <= 4'd0;
                        r_phase <= 2'd0;
                        r_acc   <= '0;
                        r_mode  <= 1'b0;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    unique case (r_phase)
                        2'd0: begin
                            r_prod  <= m_p;
                            r_phase <= 2'd1;
                        end
                        2'd1: begin
                            r_acc   <= n_acc;
                            r_prod  <= m_p;
                            r_phase <= 2'd2;
                        end
                        default: begin
                            r_phase <= 2'd0;
                            r_acc   <= expr_end ? '0 : n_acc;
                            if (!r_mode) begin
                                unique case (cur.dest)
                                    tacs_pkg::D_A:   r_ca  <= n_acc[WC-1:0];
                                    tacs_pkg::D_B:   r_cb  <= n_acc[WC-1:0];
                                    tacs_pkg::D_C:   r_cc  <= n_acc[WC-1:0];
                                    tacs_pkg::D_E:   r_ce  <= n_acc[WC-1:0];
                                    tacs_pkg::D_F:   r_cf  <= n_acc[WC-1:0];
                                    tacs_pkg::D_I:   r_ci  <= n_acc[WC-1:0];
                                    tacs_pkg::D_DET: r_det <= n_acc[WC-1:0];
                                    default: ;
                                endcase
                                if (r_term == 4'(tacs_pkg::N_COF_TERMS - 1)) begin
                                    r_state <= ST_CHECK;
                                end else begin
                                    r_term <= r_term + 4'd1;
                                end
                            end else if (r_j == 2'd2) begin
                                r_dvd <= {acc_abs[WM-tacs_pkg::SCALE_SHIFT-1:0],
                                          tacs_pkg::SCALE_SHIFT'(0)};
                                r_neg   <= n_acc[WA-1] ^ r_det[WC-1];
                                r_rem   <= '0;
                                r_bit   <= 7'd0;
                                r_state <= ST_DIV;
                            end else begin
                                r_j <= r_j + 2'd1;
                            end
                        end
                    endcase
                end
                ST_CHECK: begin
                    if (r_det == '0) begin
                        r_out   <= '{3'd0, 32'sd0, 1'b1, 1'b1};
                        r_out_v <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_dmag  <= det_abs[WC-2:0];
                        r_mode  <= 1'b1;
                        r_row   <= 2'd0;
                        r_grp   <= 1'b0;
                        r_j     <= 2'd0;
                        r_phase <= 2'd0;
                        r_acc   <= '0;
                        r_state <= ST_MAC;
                    end
                end
                ST_DIV: begin
                    r_dvd <= {r_dvd[WM-2:0], q_ge};
                    r_rem <= rem_nx[WC-2:0];
                    r_bit <= r_bit + 7'd1;
                    if (r_bit == 7'(WM - 1)) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    r_out   <= '{out_idx, sat_val, 1'b0, 1'b0};
                    r_out_v <= 1'b1;
                    r_j     <= 2'd0;
                    r_phase <= 2'd0;
                    if (r_grp && r_row == 2'd2) begin
                        r_state <= ST_SCALE;
                    end else begin
                        if (r_row == 2'd2) begin
                            r_row <= 2'd0;
                            r_grp <= 1'b1;
                        end else begin
                            r_row <= r_row + 2'd1;
                        end
                        r_state <= ST_MAC;
                    end
                end
                ST_SCALE: begin
                    r_out   <= '{tacs_pkg::IDX_SCALE, 32'sd1 <<< tacs_pkg::SCALE_SHIFT,
                                 1'b0, 1'b1};
                    r_out_v <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_out_v;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ----- src/touch_affine_calibration_solver.sv -----
`default_nettype none

// Channel  | Direction | Handshake            | Beat
// ---------+-----------+----------------------+-------------------------------
// point    | in        | i_start, o_busy      | i_item: touch and target pair
// result   | out       | o_strobe (one cycle) | o_result: coefficient beat
//
// A point beat is taken in any cycle where i_start is high and o_busy is low.
// After the last point of a run the solver computes the cofactors and the
// determinant by shared multiply-accumulate; unless the determinant is zero, it
// then runs, for each of six coefficients, a multiply-accumulate and the
// bit-serial divider. o_busy rises only when two finished runs wait for the
// solver. Reset is synchronous and clears the sums and the sequencer.
module touch_affine_calibration_solver #(
    parameter int NUM_POINTS = tacs_pkg::NUM_POINTS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire tacs_pkg::t_item i_item,
    output logic                 o_busy,
    output logic                 o_strobe,
    output tacs_pkg::t_result    o_result
);

    logic            push;
    tacs_pkg::t_sums push_data;
    logic            pop;
    tacs_pkg::t_sums q_data;
    logic [1:0]      q_count;

    tacs_front #(.NUM_POINTS(NUM_POINTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_item      (i_item),
        .i_q_count   (q_count),
        .o_busy      (o_busy),
        .o_push      (push),
        .o_push_data (push_data)
    );

    tacs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_count (q_count)
    );

    tacs_solver #(.NUM_POINTS(NUM_POINTS)) u_solver (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_count (q_count),
        .i_q_data  (q_data),
        .o_q_pop   (pop),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

    a_singular_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.singular |-> o_result.last)
        else $error("singular beat without last");

    a_scale_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.coef_index == tacs_pkg::IDX_SCALE
        |-> o_result.last && !o_result.singular)
        else $error("scale beat malformed");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count != 2'd3)
        else $error("queue overflow");

    a_empty_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count == 2'd0 |-> !o_busy)
        else $error("busy with empty queue");

endmodule

`default_nettype wire

// ----- sim/tacs_checker.sv -----
`default_nettype none

module tacs_checker #(
    parameter int NUM_POINTS = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire tacs_pkg::t_item   i_item,
    input  wire logic              i_strobe,
    input  wire tacs_pkg::t_result i_result,
    output int                     o_errors,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [159:0] t_wide;

    tacs_pkg::t_result coef_fifo[$];
    int      n_pts;
    t_wide   s_x, s_y, s_xx, s_yy, s_xy;
    t_wide   z_sum[2][3];

    function automatic logic signed [31:0] div_trunc_sat(input t_wide num, input t_wide den);
        t_wide q;
        q = num / den;
        if (q > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (q < -64'sd2147483648) return 32'sh80000000;
        return q[31:0];
    endfunction

    task automatic solve_calibration();
        t_wide   n, a, b, c, e, f, ii, det, acc;
        t_wide   cof[3][3];
        tacs_pkg::t_result r;
        n   = NUM_POINTS;
        a   = s_xx * s_yy - s_xy * s_xy;
        b   = s_xy * s_y - s_x * s_yy;
        c   = s_x * s_xy - s_y * s_xx;
        e   = n * s_yy - s_y * s_y;
        f   = s_x * s_y - n * s_xy;
        ii  = n * s_xx - s_x * s_x;
        det = n * a + s_x * b + s_y * c;
        cof = '{'{a, b, c}, '{b, e, f}, '{c, f, ii}};
        if (det == 0) begin
            r = '{3'd0, 32'sd0, 1'b1, 1'b1};
            coef_fifo.push_back(r);
        end else begin
            for (int g = 0; g < 2; g++) begin
                for (int k = 0; k < 3; k++) begin
                    acc = cof[k][0] * z_sum[g][0] + cof[k][1] * z_sum[g][1]
                        + cof[k][2] * z_sum[g][2];
                    acc = acc * 65536;
                    r = '{3'(g * 3 + k), div_trunc_sat(acc, det), 1'b0, 1'b0};
                    coef_fifo.push_back(r);
                end
            end
            r = '{tacs_pkg::IDX_SCALE, 32'sd65536, 1'b0, 1'b1};
            coef_fifo.push_back(r);
        end
    endtask

    task automatic clear_sums();
        n_pts = 0;
        s_x = 0; s_y = 0; s_xx = 0; s_yy = 0; s_xy = 0;
        for (int g = 0; g < 2; g++)
            for (int k = 0; k < 3; k++)
                z_sum[g][k] = 0;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
        clear_sums();
    end

    always @(posedge i_clk) begin
        tacs_pkg::t_result exp_r;
        t_wide   tx, ty, sx, sy;
        if (!i_rst_n) begin
            clear_sums();
            coef_fifo.delete();
        end else begin
            if (i_strobe) begin
                if (coef_fifo.size() == 0) begin
                    $display("%0t: unexpected result beat: actual %p", $time, i_result);
                    o_errors++;
                end else begin
                    exp_r = coef_fifo.pop_front();
                    if (i_result.coef_index !== exp_r.coef_index
                        || i_result.coef_value !== exp_r.coef_value
                        || i_result.singular !== exp_r.singular
                        || i_result.last !== exp_r.last) begin
                        $display("%0t: mismatch: expected %p actual %p",
                                 $time, exp_r, i_result);
                        o_errors++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                tx = i_item.touch_x;
                ty = i_item.touch_y;
                sx = i_item.target_x;
                sy = i_item.target_y;
                s_x  += tx;      s_y  += ty;
                s_xx += tx * tx; s_yy += ty * ty; s_xy += tx * ty;
                z_sum[0][0] += sx; z_sum[0][1] += sx * tx; z_sum[0][2] += sx * ty;
                z_sum[1][0] += sy; z_sum[1][1] += sy * tx; z_sum[1][2] += sy * ty;
                n_pts++;
                if (n_pts == NUM_POINTS) begin
                    solve_calibration();
                    clear_sums();
                end
            end
        end
        o_pending = coef_fifo.size();
    end
endmodule

`default_nettype wire

// ----- sim/tb_touch_affine_calibration_solver.sv -----
`default_nettype none

module tb_touch_affine_calibration_solver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS      = tacs_pkg::NUM_POINTS_DEF;
    localparam int N_RANDOM  = 110;
    localparam int MAX_CYCLE = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    tacs_pkg::t_item   i_item = '0;
    logic              o_busy;
    logic              o_strobe;
    tacs_pkg::t_result o_result;
    int      errors;
    int      pending;
    int      cycles = 0;
    bit      quiet = 1'b0;

    always #1 i_clk = ~i_clk;

    touch_affine_calibration_solver #(.NUM_POINTS(NPTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(i_item),
        .o_busy(o_busy), .o_strobe(o_strobe), .o_result(o_result)
    );

    tacs_checker #(.NUM_POINTS(NPTS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_item(i_item), .i_strobe(o_strobe), .i_result(o_result),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_point(input tacs_pkg::t_item it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    function automatic tacs_pkg::t_item rand_point();
        return '{12'($urandom), 12'($urandom), 10'($urandom), 10'($urandom)};
    endfunction

    function automatic tacs_pkg::t_item near_point(input int tx, input int ty);
        tacs_pkg::t_item it;
        it.touch_x  = 12'(tx + $urandom_range(0, 40));
        it.touch_y  = 12'(ty + $urandom_range(0, 40));
        it.target_x = 10'((tx * 1000) / 4096 + $urandom_range(0, 8));
        it.target_y = 10'((ty * 1000) / 4096 + $urandom_range(0, 8));
        return it;
    endfunction

    initial begin
        int mode;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NPTS; k++) send_point('{12'd2048, 12'd2048, 10'd512, 10'd512});
        send_point('{12'd0, 12'd0, 10'd0, 10'd0});
        send_point('{12'd4095, 12'd0, 10'd1023, 10'd0});
        send_point('{12'd0, 12'd4095, 10'd0, 10'd1023});
        send_point('{12'd4095, 12'd4095, 10'd1023, 10'd1023});
        send_point('{12'd2048, 12'd2048, 10'd512, 10'd512});
        send_point('{12'd4095, 12'd4095, 10'd0, 10'd0});
        send_point('{12'd4094, 12'd4095, 10'd1023, 10'd1023});
        send_point('{12'd4095, 12'd4094, 10'd1023, 10'd0});
        send_point('{12'd4095, 12'd4095, 10'd0, 10'd1023});
        send_point('{12'd4094, 12'd4094, 10'd1023, 10'd1023});
        for (int k = 0; k < NPTS; k++) send_point('{12'(k * 10), 12'(k * 20), 10'd0, 10'd1023});

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k >= N_RANDOM - 20) quiet = 1'b1;
            mode = $urandom_range(0, 9);
            if (mode < 6) send_point(near_point(($urandom_range(0, 4) * 950),
                                                ($urandom_range(0, 4) * 950)));
            else if (mode < 8) send_point(rand_point());
            else send_point('{12'($urandom_range(0, 2) * 2000), 12'd1000,
                             10'($urandom), 10'($urandom)});
        end
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

`default_nettype wire
